// File: hw/rtl/fspx_pkg.sv
// Package: shared constants and codes for the float sample to pixel converter.
`timescale 1ns / 1ps
package fspx_pkg;
  localparam int SAMPLE_W = 32;
  localparam int PACKED_W = 32;
  localparam int COUNT_W  = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [1:0] FMT_UNORM  = 2'd0;
  localparam logic [1:0] FMT_HALF   = 2'd1;
  localparam logic [1:0] FMT_SINGLE = 2'd2;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_BITS   = 2'd1;
  localparam logic [1:0] REG_LE     = 2'd2;

  localparam logic [1:0] FORMAT_RST = FMT_UNORM;
  localparam logic [4:0] BITS_RST   = 5'd8;
  localparam logic       LE_RST     = 1'b1;

  localparam logic [4:0] BITS_MAX   = 5'd16;
  localparam logic [4:0] BITS_BYTE  = 5'd8;
  localparam logic [7:0] EXP_MAX    = 8'hff;
  localparam logic [7:0] EXP_ONE    = 8'd127;
  localparam logic [2:0] CNT_ONE    = 3'd1;
  localparam logic [2:0] CNT_TWO    = 3'd2;
  localparam logic [2:0] CNT_FOUR   = 3'd4;
endpackage

// File: hw/rtl/fspx_if.sv
// Interfaces: sample, pixel and configuration channels.
`timescale 1ns / 1ps
interface fspx_in_if import fspx_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_bits;
  logic                last_sample;
  modport source (output valid, sample_bits, last_sample, input ready);
  modport sink (input valid, sample_bits, last_sample, output ready);
endinterface

interface fspx_out_if import fspx_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PACKED_W-1:0] packed_bytes;
  logic [COUNT_W-1:0]  byte_count;
  logic                last_out;
  modport source (output valid, packed_bytes, byte_count, last_out, input ready);
  modport sink (input valid, packed_bytes, byte_count, last_out, output ready);
endinterface

interface fspx_cfg_if import fspx_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/float_sample_to_external_pixel_top.sv
// Top level: float32 sample to unorm, half or single pixel bytes.
// Throughput: one transaction per cycle; the four-stage pipeline (input
// register, 24x16 multiply and half conversion, float rounding, integer
// rounding and packing) stalls as a whole only while the output register holds.
// Reset: rst_n synchronous, clears valid bits and sets format, bits and endian.
`timescale 1ns / 1ps
module float_sample_to_external_pixel_top import fspx_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  fspx_in_if.sink    in_if,
  fspx_out_if.source out_if,
  fspx_cfg_if.sink   cfg_if
);
  logic [1:0] fmt_r;
  logic [4:0] ibits_r;
  logic       le_r;

  logic en;
  logic v0_r, v1_r, v2_r, v3_r;

  logic [31:0] s0_r;
  logic        l0_r;

  logic [31:0] s1_r;
  logic        l1_r;
  logic [39:0] p1_r;
  logic [7:0]  e1_r;
  logic [4:0]  n1_r;
  logic        z1_r;
  logic [15:0] h1_r;

  logic [31:0] s2_r;
  logic        l2_r;
  logic [24:0] q2_r;
  logic [7:0]  sh2_r;
  logic        z2_r;
  logic [15:0] h2_r;

  logic [31:0] pk_r;
  logic [2:0]  cnt_r;
  logic        l3_r;

  logic [31:0] pk_nxt;
  logic [2:0]  cnt_nxt;
  logic [39:0] p1_nxt;
  logic [7:0]  e1_nxt;
  logic [4:0]  n1_nxt;
  logic        z1_nxt;
  logic [15:0] h1_nxt;
  logic [24:0] q2_nxt;
  logic [7:0]  sh2_nxt;

  assign en           = !v3_r || out_if.ready;
  assign in_if.ready  = en;
  assign cfg_if.ready = 1'b1;
  assign out_if.valid        = v3_r;
  assign out_if.packed_bytes = pk_r;
  assign out_if.byte_count   = cnt_r;
  assign out_if.last_out     = l3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= FORMAT_RST;
      ibits_r <= BITS_RST;
      le_r    <= LE_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_FORMAT: fmt_r   <= cfg_if.data[1:0];
        REG_BITS:   ibits_r <= cfg_if.data;
        REG_LE:     le_r    <= cfg_if.data[0];
        default: ;
      endcase
    end
  end

  // stage 1: clamp, multiply, half conversion
  always_comb begin
    logic        sg;
    logic [7:0]  e;
    logic [22:0] m;
    logic [23:0] sig;
    logic [15:0] mul;
    logic [15:0] hs;
    logic [14:0] h;
    logic [12:0] rem;
    logic [4:0]  sft;
    logic [23:0] sub, srem, shalf;
    sg  = s0_r[31];
    e   = s0_r[30:23];
    m   = s0_r[22:0];
    n1_nxt = (ibits_r > BITS_MAX) ? BITS_MAX : ibits_r;
    mul = 16'((17'd1 << n1_nxt) - 17'd1);
    z1_nxt = sg || (e == 8'd0) || (e == EXP_MAX && m != 23'd0) || (n1_nxt == 5'd0);
    if (e >= EXP_ONE) begin
      sig    = 24'h800000;
      e1_nxt = EXP_ONE;
    end else begin
      sig    = {1'b1, m};
      e1_nxt = e;
    end
    p1_nxt = {16'd0, sig} * {24'd0, mul};

    hs = {sg, 15'd0};
    h  = '0;
    rem = m[12:0];
    sft = 5'd0;
    sub = '0;
    srem = '0;
    shalf = '0;
    if (e == EXP_MAX) begin
      h1_nxt = (m != 23'd0) ? (hs | 16'h7e00 | {6'd0, m[22:13]}) : (hs | 16'h7c00);
    end else if (e == 8'd0) begin
      h1_nxt = hs;
    end else if (e >= 8'd143) begin
      h1_nxt = hs | 16'h7c00;
    end else if (e >= 8'd113) begin
      h = {5'(e - 8'd112), m[22:13]};
      if (rem > 13'h1000 || (rem == 13'h1000 && h[0]))
        h = h + 15'd1;
      h1_nxt = hs | {1'b0, h};
    end else if (e < 8'd102) begin
      h1_nxt = hs;
    end else begin
      sft   = 5'(8'd126 - e);
      sub   = {1'b1, m} >> sft;
      srem  = {1'b1, m} & ((24'd1 << sft) - 24'd1);
      shalf = 24'd1 << (sft - 5'd1);
      if (srem > shalf || (srem == shalf && sub[0]))
        sub = sub + 24'd1;
      h1_nxt = hs | {1'b0, sub[14:0]};
    end
  end

  // stage 2: round product to float32 precision
  always_comb begin
    logic        hi;
    logic [4:0]  d;
    logic [39:0] t, rm, hf;
    hi = p1_r[6'd23 + 6'(n1_r)];
    d  = hi ? n1_r : (n1_r - 5'd1);
    t  = p1_r >> d;
    rm = p1_r & ((40'd1 << d) - 40'd1);
    hf = 40'd1 << (d - 5'd1);
    q2_nxt = t[24:0];
    if (d != 5'd0 && (rm > hf || (rm == hf && t[0])))
      q2_nxt = t[24:0] + 25'd1;
    sh2_nxt = 8'(9'd150 - {1'b0, e1_r} - {4'd0, d});
  end

  // stage 3: round to integer, order bytes
  always_comb begin
    logic [24:0] t, rm, hf;
    logic [15:0] v, w;
    t  = q2_r >> sh2_r;
    rm = q2_r & ((25'd1 << sh2_r[4:0]) - 25'd1);
    hf = 25'd1 << (sh2_r[4:0] - 5'd1);
    if (z2_r || sh2_r >= 8'd26) begin
      v = 16'd0;
    end else if (rm > hf || (rm == hf && t[0])) begin
      v = t[15:0] + 16'd1;
    end else begin
      v = t[15:0];
    end
    w = (fmt_r == FMT_HALF) ? h2_r : v;
    case (fmt_r)
      FMT_UNORM, FMT_HALF: begin
        if (fmt_r == FMT_UNORM && ibits_r <= BITS_BYTE) begin
          pk_nxt  = {24'd0, v[7:0]};
          cnt_nxt = CNT_ONE;
        end else begin
          pk_nxt  = le_r ? {16'd0, w} : {16'd0, w[7:0], w[15:8]};
          cnt_nxt = CNT_TWO;
        end
      end
      default: begin
        pk_nxt  = le_r ? s2_r : {s2_r[7:0], s2_r[15:8], s2_r[23:16], s2_r[31:24]};
        cnt_nxt = CNT_FOUR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_if.valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r  <= in_if.sample_bits;
      l0_r  <= in_if.last_sample;
      s1_r  <= s0_r;
      l1_r  <= l0_r;
      p1_r  <= p1_nxt;
      e1_r  <= e1_nxt;
      n1_r  <= n1_nxt;
      z1_r  <= z1_nxt;
      h1_r  <= h1_nxt;
      s2_r  <= s1_r;
      l2_r  <= l1_r;
      q2_r  <= q2_nxt;
      sh2_r <= sh2_nxt;
      z2_r  <= z1_r;
      h2_r  <= h1_r;
      pk_r  <= pk_nxt;
      cnt_r <= cnt_nxt;
      l3_r  <= l2_r;
    end
  end

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> v0_r)
    else $error("accepted transaction lost at stage 0");
  a_move: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && en) |=> v3_r)
    else $error("stage 2 item did not reach output");
  a_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.byte_count == CNT_ONE) |-> (out_if.packed_bytes[31:8] == 24'd0))
    else $error("single byte result has upper bits set");
  a_two: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.byte_count == CNT_TWO) |-> (out_if.packed_bytes[31:16] == 16'd0))
    else $error("two byte result has upper bits set");
endmodule

// File: tb/sv/float_sample_to_external_pixel_top_tb.sv
// Testbench: float sample to pixel converter, scoreboard checked against a bit-exact predictor.
`timescale 1ns / 1ps
module float_sample_to_external_pixel_top_tb;
  import fspx_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic [PACKED_W-1:0] packed_bytes;
    logic [COUNT_W-1:0]  byte_count;
    logic                last_out;
  } pixel_t;

  class pixel_scoreboard;
    logic [1:0] fmt;
    logic [4:0] nbits;
    logic       le;
    pixel_t     pending_pixels[$];

    function new();
      fmt   = FORMAT_RST;
      nbits = BITS_RST;
      le    = LE_RST;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_FORMAT: fmt   = d[1:0];
        REG_BITS:   nbits = d;
        REG_LE:     le    = d[0];
        default: ;
      endcase
    endfunction

    function logic [15:0] unorm_of(logic [31:0] b);
      logic [4:0]  n;
      logic [63:0] mul, mant, prod, q, r, hf, pq;
      int          e, sc, len, k;
      n   = (nbits > BITS_MAX) ? BITS_MAX : nbits;
      mul = (64'd1 << n) - 64'd1;
      e   = int'(b[30:23]);
      if (b[31] || b[30:0] == 31'd0 || (e == 255 && b[22:0] != 23'd0)) return 16'd0;
      if (b[30:0] > 31'h3f800000) return mul[15:0];
      mant = (e == 0) ? {41'd0, b[22:0]} : {40'd0, 1'b1, b[22:0]};
      sc   = (e == 0) ? 149 : 150 - e;
      prod = mant * mul;
      if (prod == 64'd0) return 16'd0;
      len = 0;
      for (int i = 0; i < 64; i++) if (prod[i]) len = i + 1;
      if (len > 24) begin
        k  = len - 24;
        q  = prod >> k;
        r  = prod & ((64'd1 << k) - 64'd1);
        hf = 64'd1 << (k - 1);
        if (r > hf || (r == hf && q[0])) q = q + 64'd1;
        pq = q << k;
      end else begin
        pq = prod;
      end
      if (sc >= 63) return 16'd0;
      q  = pq >> sc;
      r  = pq & ((64'd1 << sc) - 64'd1);
      hf = 64'd1 << (sc - 1);
      if (r > hf || (r == hf && q[0])) q = q + 64'd1;
      return q[15:0];
    endfunction

    function logic [15:0] half_of(logic [31:0] b);
      logic [15:0] sgn;
      logic [31:0] m, h, r, sig, hf;
      int          e, he, sh;
      sgn = {b[31], 15'd0};
      e   = int'(b[30:23]);
      m   = {9'd0, b[22:0]};
      if (e == 255) begin
        if (m != 0) return sgn | 16'h7e00 | {6'd0, m[22:13]};
        return sgn | 16'h7c00;
      end
      if (e == 0) return sgn;
      he = e - 127 + 15;
      if (he >= 31) return sgn | 16'h7c00;
      if (he >= 1) begin
        h = (he << 10) | (m >> 13);
        r = m & 32'h1fff;
        if (r > 32'h1000 || (r == 32'h1000 && h[0])) h = h + 1;
        return sgn | h[15:0];
      end
      if (he < -10) return sgn;
      sh  = 14 - he;
      sig = m | 32'h800000;
      h   = sig >> sh;
      r   = sig & ((32'd1 << sh) - 1);
      hf  = 32'd1 << (sh - 1);
      if (r > hf || (r == hf && h[0])) h = h + 1;
      return sgn | h[15:0];
    endfunction

    function logic [31:0] order16(logic [15:0] v);
      return le ? {16'd0, v} : {16'd0, v[7:0], v[15:8]};
    endfunction

    function void note_sample(logic [31:0] b, logic l);
      pixel_t p;
      logic [15:0] v;
      p.last_out = l;
      if (fmt == FMT_UNORM) begin
        v = unorm_of(b);
        if (nbits <= BITS_BYTE) begin
          p.packed_bytes = {24'd0, v[7:0]};
          p.byte_count   = CNT_ONE;
        end else begin
          p.packed_bytes = order16(v);
          p.byte_count   = CNT_TWO;
        end
      end else if (fmt == FMT_HALF) begin
        p.packed_bytes = order16(half_of(b));
        p.byte_count   = CNT_TWO;
      end else begin
        p.packed_bytes = le ? b : {b[7:0], b[15:8], b[23:16], b[31:24]};
        p.byte_count   = CNT_FOUR;
      end
      pending_pixels.push_back(p);
    endfunction

    function string check_pixel(pixel_t got);
      pixel_t exp_p;
      string  msg;
      if (pending_pixels.size() == 0) begin
        return $sformatf("unexpected pixel %h", got);
      end
      exp_p = pending_pixels.pop_front();
      msg = "";
      if (got.packed_bytes !== exp_p.packed_bytes)
        msg = {msg, $sformatf(" packed_bytes %h exp %h", got.packed_bytes, exp_p.packed_bytes)};
      if (got.byte_count !== exp_p.byte_count)
        msg = {msg, $sformatf(" byte_count %0d exp %0d", got.byte_count, exp_p.byte_count)};
      if (got.last_out !== exp_p.last_out)
        msg = {msg, $sformatf(" last_out %b exp %b", got.last_out, exp_p.last_out)};
      return msg;
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   errors;
  bit   in_burst;
  bit   out_burst;
  pixel_scoreboard sb;

  fspx_in_if  in_if();
  fspx_out_if out_if();
  fspx_cfg_if cfg_if();

  float_sample_to_external_pixel_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  task automatic report(input string msg);
    errors++;
    if (errors <= 50) $display("%0t mismatch:%s", $time, msg);
  endtask

  task automatic send_sample(input logic [31:0] b, input logic l);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.sample_bits <= b;
    in_if.last_sample <= l;
    do @(posedge clk); while (!in_if.ready);
    sb.note_sample(b, l);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.write_reg(idx, d);
    @(posedge clk);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_sample();
    logic [31:0] b;
    case ($urandom_range(0, 6))
      0: b = $urandom;
      1: b = {1'b0, 8'($urandom_range(100, 126)), 23'($urandom)};
      2: b = {1'($urandom), 8'($urandom_range(100, 143)), 23'($urandom)};
      3: b = {1'($urandom), 8'($urandom_range(110, 113)), 23'($urandom)};
      4: b = {1'($urandom), 8'($urandom_range(113, 142)), 10'($urandom), 13'h1000};
      5: b = {1'($urandom), 8'd0, 23'($urandom)};
      default: begin
        case ($urandom_range(0, 5))
          0: b = 32'h3f800000;
          1: b = 32'h00000000;
          2: b = 32'h80000000;
          3: b = {1'($urandom), 31'h7f800000};
          4: b = {1'($urandom), 8'hff, 22'($urandom), 1'b1};
          default: b = {1'b0, 8'd126, 23'($urandom)};
        endcase
      end
    endcase
    return b;
  endfunction

  logic [31:0] directed[] = '{
    32'h00000000, 32'h80000000, 32'h3f800000, 32'h3f000000, 32'h7fc00000,
    32'h7f800000, 32'hff800000, 32'h40000000, 32'hbf800000, 32'h00000001,
    32'h007fffff, 32'h7fffffff, 32'hffffffff, 32'h3b000000, 32'h3b800000,
    32'h477fe000, 32'h477ff000, 32'h477fefff, 32'h38800000, 32'h33800000,
    32'h33000000, 32'h33000001, 32'h7f801234, 32'hffbfe001, 32'h3effffff
  };

  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      int stall;
      pixel_t got;
      string  msg;
      stall = out_burst ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      got = {out_if.packed_bytes, out_if.byte_count, out_if.last_out};
      msg = sb.check_pixel(got);
      if (msg != "") report(msg);
      if ($urandom_range(0, 40) == 0) out_burst = ~out_burst;
    end
  end

  initial begin
    int phase_fmt[]  = '{0, 0, 1, 1, 2, 2, 3, 0, 0, 0, 0, 0, 1};
    int phase_bits[] = '{8, 16, 8, 31, 0, 16, 5, 1, 0, 31, 9, 12, 16};
    int phase_le[]   = '{1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 0};
    sb        = new();
    errors    = 0;
    in_burst  = 1'b0;
    out_burst = 1'b0;
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.sample_bits  <= '0;
    in_if.last_sample  <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= '0;
    cfg_if.data        <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_sample(directed[i], i[0]);
    for (int ph = 0; ph < phase_fmt.size(); ph++) begin
      drain();
      if (ph == 3) write_reg(REG_NONE, 5'h1f);
      write_reg(REG_FORMAT, 5'(phase_fmt[ph]) | (ph == 6 ? 5'h1c : 5'h00));
      write_reg(REG_BITS, 5'(phase_bits[ph]));
      write_reg(REG_LE, 5'(phase_le[ph]) | (ph == 9 ? 5'h1e : 5'h00));
      if (ph == 2 || ph == 4) foreach (directed[i]) send_sample(directed[i], ~i[0]);
      for (int n = 0; n < 130; n++) begin
        send_sample(rand_sample(), 1'($urandom_range(0, 7) == 0));
        if ($urandom_range(0, 30) == 0) in_burst = ~in_burst;
      end
    end
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// File: float_sample_to_external_pixel_top.f
hw/rtl/fspx_pkg.sv
hw/rtl/fspx_if.sv
hw/rtl/float_sample_to_external_pixel_top.sv
tb/sv/float_sample_to_external_pixel_top_tb.sv
